// ===== rtl/ast_pkg.sv =====
// Shared types, constants and helpers for the affine skinning transform.
// No dependencies; imported by every module of the block.
package ast_pkg;

  localparam int AstFracBits = 16;
  localparam int DataW       = 32;
  localparam int MatDepth    = 12;
  localparam int StepW       = 4;
  localparam int SumW        = DataW + 2;

  localparam logic [1:0]       LastRow  = 2'd2;
  localparam logic [StepW-1:0] LastStep = 4'd12;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_POINT    = 3'd1,
    CMD_DIR      = 3'd2,
    CMD_SKIN_SET = 3'd3,
    CMD_SKIN_ADD = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    A_VEC   = 2'd0,
    A_SHP   = 2'd1,
    A_SCALE = 2'd2
  } a_sel_e;

  typedef enum logic {
    B_MAT   = 1'b0,
    B_SCALE = 1'b1
  } b_sel_e;

  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_NO_W     = 3'd2,
    CND_ROW_MORE = 3'd3,
    CND_VEC_DONE = 3'd4
  } cond_e;

  // One microcode word.
  typedef struct packed {
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    logic [1:0]       col;
    logic             clr_sum;
    logic             add_term;
    logic             wr_res;
    logic             row_step;
    logic             set_nrm;
    logic             fin;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uop_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic       step_en;
    uop_t       uop;
    logic [1:0] row;
    logic       nrm;
  } dp_ctrl_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [DataW-1:0] r;
    begin
      if (v > SumW'($signed({1'b0, {(DataW-1){1'b1}}}))) begin
        r = {1'b0, {(DataW-1){1'b1}}};
      end else if (v < -SumW'($signed({1'b0, {(DataW-1){1'b1}}})) - SumW'(1)) begin
        r = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        r = v[DataW-1:0];
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/ast_sequencer.sv =====
// Microcode sequencer: program ROM, step counter, row and vector counters, jumps.
// Depends on ast_pkg.
module ast_sequencer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  ast_pkg::cmd_e            cmd_i,
  input  logic                     out_free_i,
  output ast_pkg::dp_ctrl_t        ctrl_o,
  output logic                     idle_o,
  output logic [ast_pkg::StepW-1:0] pc_o
);
  import ast_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  localparam logic [StepW-1:0] LblRow   = 4'd0;
  localparam logic [StepW-1:0] LblNoW   = 4'd8;
  localparam logic [StepW-1:0] LblWrite = 4'd9;
  localparam logic [StepW-1:0] LblFin   = 4'd12;

  // Program. Each term: v*m, then sat(shr)*scale; the add of a term
  // overlaps the next product.
  function automatic uop_t ucode(input logic [StepW-1:0] pc);
    uop_t u;
    begin
      u = '{a_sel: A_VEC, b_sel: B_MAT, col: 2'd0, clr_sum: 1'b0, add_term: 1'b0,
            wr_res: 1'b0, row_step: 1'b0, set_nrm: 1'b0, fin: 1'b0,
            cond: CND_NEVER, target: LblRow};
      case (pc)
        4'd0: begin u.clr_sum = 1'b1; end
        4'd1: begin u.a_sel = A_SHP; u.b_sel = B_SCALE; end
        4'd2: begin u.col = 2'd1; u.add_term = 1'b1; end
        4'd3: begin u.a_sel = A_SHP; u.b_sel = B_SCALE; end
        4'd4: begin u.col = 2'd2; u.add_term = 1'b1; end
        4'd5: begin
          u.a_sel = A_SHP; u.b_sel = B_SCALE; u.cond = CND_NO_W; u.target = LblNoW;
        end
        4'd6: begin u.a_sel = A_SCALE; u.col = 2'd3; u.add_term = 1'b1; end
        4'd7: begin u.add_term = 1'b1; u.cond = CND_ALWAYS; u.target = LblWrite; end
        4'd8: begin u.add_term = 1'b1; end
        4'd9: begin
          u.wr_res = 1'b1; u.row_step = 1'b1; u.cond = CND_ROW_MORE; u.target = LblRow;
        end
        4'd10: begin u.cond = CND_VEC_DONE; u.target = LblFin; end
        4'd11: begin u.set_nrm = 1'b1; u.cond = CND_ALWAYS; u.target = LblRow; end
        4'd12: begin u.fin = 1'b1; end
        default: begin end
      endcase
      return u;
    end
  endfunction

  seq_state_e       state_q, state_d;
  logic [StepW-1:0] pc_q, pc_d;
  logic [1:0]       row_q, row_d;
  logic             nrm_q, nrm_d;
  uop_t             uop;
  logic             step_en;
  logic             take;
  logic             with_w;
  logic             skin;

  assign uop     = ucode(pc_q);
  assign step_en = (state_q == ST_RUN) && !(uop.fin && !out_free_i);
  assign with_w  = (cmd_i != CMD_DIR) && !nrm_q;
  assign skin    = (cmd_i == CMD_SKIN_SET) || (cmd_i == CMD_SKIN_ADD);

  always_comb begin
    case (uop.cond)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_W:     take = !with_w;
      CND_ROW_MORE: take = (row_q != LastRow);
      CND_VEC_DONE: take = nrm_q || !skin;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    row_d   = row_q;
    nrm_d   = nrm_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          pc_d    = LblRow;
          row_d   = 2'd0;
          nrm_d   = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_en) begin
          if (uop.fin) state_d = ST_IDLE;
          pc_d = take ? uop.target : pc_q + 1'b1;
          if (uop.row_step) row_d = (row_q == LastRow) ? 2'd0 : row_q + 1'b1;
          if (uop.set_nrm) nrm_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      row_q   <= '0;
      nrm_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      row_q   <= row_d;
      nrm_q   <= nrm_d;
    end
  end

  assign ctrl_o = '{step_en: step_en, uop: uop, row: row_q, nrm: nrm_q};
  assign idle_o = (state_q == ST_IDLE);
  assign pc_o   = pc_q;

endmodule

// ===== rtl/ast_datapath.sv =====
// Datapath: matrix registers, shared 32x32 multiplier, row sum, results, accumulators.
// Depends on ast_pkg; driven by ast_sequencer control.
module ast_datapath #(
  parameter int FRAC_BITS = ast_pkg::AstFracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            ld_en_i,
  input  logic [3:0]                      element_index_i,
  input  logic signed [ast_pkg::DataW-1:0] element_value_i,
  input  logic                            cap_en_i,
  input  logic signed [ast_pkg::DataW-1:0] pos_x_i,
  input  logic signed [ast_pkg::DataW-1:0] pos_y_i,
  input  logic signed [ast_pkg::DataW-1:0] pos_z_i,
  input  logic signed [ast_pkg::DataW-1:0] nrm_x_i,
  input  logic signed [ast_pkg::DataW-1:0] nrm_y_i,
  input  logic signed [ast_pkg::DataW-1:0] nrm_z_i,
  input  logic signed [ast_pkg::DataW-1:0] scale_i,
  input  ast_pkg::cmd_e                   cmd_i,
  input  ast_pkg::dp_ctrl_t               ctrl_i,
  output logic signed [ast_pkg::DataW-1:0] out_pos_x_o,
  output logic signed [ast_pkg::DataW-1:0] out_pos_y_o,
  output logic signed [ast_pkg::DataW-1:0] out_pos_z_o,
  output logic signed [ast_pkg::DataW-1:0] out_nrm_x_o,
  output logic signed [ast_pkg::DataW-1:0] out_nrm_y_o,
  output logic signed [ast_pkg::DataW-1:0] out_nrm_z_o
);
  import ast_pkg::*;

  localparam int ProdW = 2 * DataW;

  logic signed [DataW-1:0] mat_q [MatDepth];
  logic signed [DataW-1:0] vpos_q [3];
  logic signed [DataW-1:0] vnrm_q [3];
  logic signed [DataW-1:0] scale_q;
  logic signed [ProdW-1:0] p_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [DataW-1:0] res_pos_q [3];
  logic signed [DataW-1:0] res_nrm_q [3];
  logic signed [DataW-1:0] acc_pos_q [3];
  logic signed [DataW-1:0] acc_nrm_q [3];
  logic signed [DataW-1:0] out_pos_q [3];
  logic signed [DataW-1:0] out_nrm_q [3];

  logic signed [DataW-1:0] mat_rd;
  logic signed [DataW-1:0] vsrc;
  logic signed [DataW-1:0] op_a;
  logic signed [DataW-1:0] op_b;
  logic signed [ProdW-1:0] p_shr;
  logic signed [DataW-1:0] shp;
  logic                    p_fits;
  logic signed [DataW-1:0] add_pos [3];
  logic signed [DataW-1:0] add_nrm [3];
  logic                    fin_en;

  assign fin_en = ctrl_i.step_en && ctrl_i.uop.fin;
  assign mat_rd = mat_q[{ctrl_i.row, ctrl_i.uop.col}];

  always_comb begin
    case (ctrl_i.uop.col)
      2'd0:    vsrc = ctrl_i.nrm ? vnrm_q[0] : vpos_q[0];
      2'd1:    vsrc = ctrl_i.nrm ? vnrm_q[1] : vpos_q[1];
      2'd2:    vsrc = ctrl_i.nrm ? vnrm_q[2] : vpos_q[2];
      default: vsrc = '0;
    endcase
  end

  // floor shift back to the fixed point, then saturate
  assign p_shr  = p_q >>> FRAC_BITS;
  assign p_fits = (&p_shr[ProdW-1:DataW-1]) || !(|p_shr[ProdW-1:DataW-1]);
  assign shp    = p_fits ? p_shr[DataW-1:0]
                         : (p_shr[ProdW-1] ? {1'b1, {(DataW-1){1'b0}}}
                                           : {1'b0, {(DataW-1){1'b1}}});

  always_comb begin
    case (ctrl_i.uop.a_sel)
      A_VEC:   op_a = vsrc;
      A_SHP:   op_a = shp;
      A_SCALE: op_a = scale_q;
      default: op_a = '0;
    endcase
    case (ctrl_i.uop.b_sel)
      B_MAT:   op_b = mat_rd;
      B_SCALE: op_b = scale_q;
      default: op_b = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_pos[i] = sat32(SumW'(acc_pos_q[i]) + SumW'(res_pos_q[i]));
      add_nrm[i] = sat32(SumW'(acc_nrm_q[i]) + SumW'(res_nrm_q[i]));
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MatDepth; i++) mat_q[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_pos_q[i] <= '0;
        acc_nrm_q[i] <= '0;
      end
    end else begin
      if (ld_en_i && (element_index_i < 4'(MatDepth))) begin
        mat_q[element_index_i] <= element_value_i;
      end
      if (fin_en) begin
        for (int i = 0; i < 3; i++) begin
          case (cmd_i)
            CMD_SKIN_SET: begin
              acc_pos_q[i] <= res_pos_q[i];
              acc_nrm_q[i] <= res_nrm_q[i];
            end
            CMD_SKIN_ADD: begin
              acc_pos_q[i] <= add_pos[i];
              acc_nrm_q[i] <= add_nrm[i];
            end
            default: begin end
          endcase
        end
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk_i) begin
    if (cap_en_i) begin
      vpos_q[0] <= pos_x_i;
      vpos_q[1] <= pos_y_i;
      vpos_q[2] <= pos_z_i;
      vnrm_q[0] <= nrm_x_i;
      vnrm_q[1] <= nrm_y_i;
      vnrm_q[2] <= nrm_z_i;
      scale_q   <= scale_i;
    end
    if (ctrl_i.step_en) begin
      p_q <= op_a * op_b;
      if (ctrl_i.uop.clr_sum) begin
        sum_q <= '0;
      end else if (ctrl_i.uop.add_term) begin
        sum_q <= sum_q + SumW'(shp);
      end
      if (ctrl_i.uop.wr_res) begin
        if (ctrl_i.nrm) res_nrm_q[ctrl_i.row] <= sat32(sum_q);
        else            res_pos_q[ctrl_i.row] <= sat32(sum_q);
      end
    end
    if (fin_en) begin
      for (int i = 0; i < 3; i++) begin
        case (cmd_i)
          CMD_SKIN_SET: begin
            out_pos_q[i] <= res_pos_q[i];
            out_nrm_q[i] <= res_nrm_q[i];
          end
          CMD_SKIN_ADD: begin
            out_pos_q[i] <= add_pos[i];
            out_nrm_q[i] <= add_nrm[i];
          end
          default: begin
            out_pos_q[i] <= res_pos_q[i];
            out_nrm_q[i] <= '0;
          end
        endcase
      end
    end
  end

  assign out_pos_x_o = out_pos_q[0];
  assign out_pos_y_o = out_pos_q[1];
  assign out_pos_z_o = out_pos_q[2];
  assign out_nrm_x_o = out_nrm_q[0];
  assign out_nrm_y_o = out_nrm_q[1];
  assign out_nrm_z_o = out_nrm_q[2];

endmodule

// ===== rtl/affine_skinning_transform.sv =====
// Top level of the affine skinning transform: handshakes, sequencer and datapath.
// Depends on ast_pkg, ast_sequencer and ast_datapath.

// A 3x4 affine matrix in signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default) is loaded one element per load beat and transforms points (with the
// translation column), directions (without) or a position/normal pair for skinning,
// every product scaled by scale_factor, each product floor-shifted and saturated,
// row sums saturated to 32 bits. One item is processed at a time. A load, or an
// unused command, yields no result and leaves the block ready. The other commands
// run a 13-word microprogram on one shared 32x32 multiplier, two multiplier passes
// per vector term and one for the translation term; the block is ready again
// once the final step has run. The result sits in an output register, so the
// next item may be accepted before it is taken; only the final step of the
// following item waits for the output to drain.
module affine_skinning_transform #(
  parameter int FRAC_BITS = ast_pkg::AstFracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      command_i,
  input  logic [3:0]                      element_index_i,
  input  logic signed [ast_pkg::DataW-1:0] element_value_i,
  input  logic signed [ast_pkg::DataW-1:0] pos_x_i,
  input  logic signed [ast_pkg::DataW-1:0] pos_y_i,
  input  logic signed [ast_pkg::DataW-1:0] pos_z_i,
  input  logic signed [ast_pkg::DataW-1:0] nrm_x_i,
  input  logic signed [ast_pkg::DataW-1:0] nrm_y_i,
  input  logic signed [ast_pkg::DataW-1:0] nrm_z_i,
  input  logic signed [ast_pkg::DataW-1:0] scale_factor_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [ast_pkg::DataW-1:0] out_pos_x_o,
  output logic signed [ast_pkg::DataW-1:0] out_pos_y_o,
  output logic signed [ast_pkg::DataW-1:0] out_pos_z_o,
  output logic signed [ast_pkg::DataW-1:0] out_nrm_x_o,
  output logic signed [ast_pkg::DataW-1:0] out_nrm_y_o,
  output logic signed [ast_pkg::DataW-1:0] out_nrm_z_o
);
  import ast_pkg::*;

  logic             accept;
  logic             start;
  logic             load;
  logic             seq_idle;
  logic             out_free;
  logic             fin_fire;
  logic             out_valid_q, out_valid_d;
  cmd_e             cmd_q;
  dp_ctrl_t         ctrl;
  logic [StepW-1:0] pc;

  assign in_ready_o = seq_idle;
  assign accept     = in_valid_i && in_ready_o;
  // commands that run the microprogram; loads are written directly
  assign start      = accept && ((command_i == CMD_POINT) || (command_i == CMD_DIR) ||
                                 (command_i == CMD_SKIN_SET) || (command_i == CMD_SKIN_ADD));
  assign load       = accept && (command_i == CMD_LOAD);

  // the final step stalls until the output register is free
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_fire   = ctrl.step_en && ctrl.uop.fin;

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_e'(command_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (fin_fire)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ast_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (cmd_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .idle_o     (seq_idle),
    .pc_o       (pc)
  );

  ast_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ld_en_i         (load),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .cap_en_i        (start),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .nrm_x_i         (nrm_x_i),
    .nrm_y_i         (nrm_y_i),
    .nrm_z_i         (nrm_z_i),
    .scale_i         (scale_factor_i),
    .cmd_i           (cmd_q),
    .ctrl_i          (ctrl),
    .out_pos_x_o     (out_pos_x_o),
    .out_pos_y_o     (out_pos_y_o),
    .out_pos_z_o     (out_pos_z_o),
    .out_nrm_x_o     (out_nrm_x_o),
    .out_nrm_y_o     (out_nrm_y_o),
    .out_nrm_z_o     (out_nrm_z_o)
  );

`ifndef NO_ASSERTIONS
  // a transform beat occupies the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o) else $error("sequencer not busy after transform beat");

  // loads take no sequencer time
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> in_ready_o) else $error("not ready after load beat");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |-> out_free) else $error("result overwritten");

  // the step counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (pc <= LastStep)) else $error("step counter out of program");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for affine_skinning_transform: directed and random vertex beats.
// Depends on ast_pkg and the affine_skinning_transform RTL; needs no files or arguments.

module testbench;
  import ast_pkg::*;

  typedef logic signed [DataW-1:0] fix_t;

  // One input beat as the driver presents it; gap = idle cycles before it is offered.
  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] idx;
    fix_t       val;
    fix_t       px;
    fix_t       py;
    fix_t       pz;
    fix_t       nx;
    fix_t       ny;
    fix_t       nz;
    fix_t       scale;
    logic [3:0] gap;
  } vert_req_t;

  // Result lanes: 0..2 position x/y/z, 3..5 normal x/y/z.
  typedef logic [5:0][DataW-1:0] vert_res_t;

  localparam fix_t FixOne = 32'sh0001_0000;
  localparam fix_t FixMax = 32'sh7fff_ffff;
  localparam fix_t FixMin = 32'sh8000_0000;
  localparam fix_t FixNegOne = -32'sh0001_0000;

  // Command codes the block has no use for.
  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast  = 3'd7;
  localparam logic [3:0] IdxTop        = 4'd15;

  localparam int RandBeats     = 700;
  localparam int HoldAt        = 300;   // accepted input beats before the long output stall
  localparam int HoldLen       = 400;
  localparam int DrainCycles   = 100;
  localparam int WatchdogLimit = 2000;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;

  logic       in_valid      = 1'b0;
  logic [2:0] command       = '0;
  logic [3:0] element_index = '0;
  fix_t       element_value = '0;
  fix_t       pos_x = '0, pos_y = '0, pos_z = '0;
  fix_t       nrm_x = '0, nrm_y = '0, nrm_z = '0;
  fix_t       scale_factor  = '0;
  logic       out_ready     = 1'b0;

  logic in_ready;
  logic out_valid;
  fix_t out_pos_x, out_pos_y, out_pos_z;
  fix_t out_nrm_x, out_nrm_y, out_nrm_z;

  // Beats pending for the driver, and vertex results still owed by the block.
  vert_req_t vertex_jobs [$];
  vert_res_t expected_vertices [$];

  // Predictor state: matrix and the two skinning accumulators.
  fix_t mat  [MatDepth];
  fix_t pacc [3];
  fix_t nacc [3];

  string lane_name [6] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                           "out_nrm_x", "out_nrm_y", "out_nrm_z"};

  int errors      = 0;
  int in_beats    = 0;
  int out_beats   = 0;
  int idle_cycles = 0;

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  logic in_beat  = 1'b0;
  logic out_beat = 1'b0;

  // Driver-side staging.
  vert_req_t   staged_req;
  bit          staged    = 1'b0;
  int unsigned wait_left = 0;

  // Receiver-side stall state.
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  affine_skinning_transform dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .element_index_i (element_index),
    .element_value_i (element_value),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .pos_z_i         (pos_z),
    .nrm_x_i         (nrm_x),
    .nrm_y_i         (nrm_y),
    .nrm_z_i         (nrm_z),
    .scale_factor_i  (scale_factor),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_pos_x_o     (out_pos_x),
    .out_pos_y_o     (out_pos_y),
    .out_pos_z_o     (out_pos_z),
    .out_nrm_x_o     (out_nrm_x),
    .out_nrm_y_o     (out_nrm_y),
    .out_nrm_z_o     (out_nrm_z)
  );

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic fix_t clamp_fix(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) return FixMax;
    if (v < 64'shffff_ffff_8000_0000) return FixMin;
    return v[DataW-1:0];
  endfunction

  // Product floor-shifted back to Q16.16, then saturated.
  function automatic fix_t fx_mul(input fix_t a, input fix_t b);
    logic signed [63:0] aw;
    logic signed [63:0] bw;
    logic signed [63:0] p;
    aw = a;
    bw = b;
    p  = aw * bw;
    return clamp_fix(p >>> AstFracBits);
  endfunction

  // One matrix row against a vector, every term scaled; with_w adds translation.
  function automatic fix_t row_dot(input int row, input fix_t v0, input fix_t v1,
                                   input fix_t v2, input fix_t s, input bit with_w);
    logic signed [63:0] acc;
    acc = 0;
    acc += fx_mul(fx_mul(v0, mat[row*4]), s);
    acc += fx_mul(fx_mul(v1, mat[row*4+1]), s);
    acc += fx_mul(fx_mul(v2, mat[row*4+2]), s);
    if (with_w) acc += fx_mul(mat[row*4+3], s);
    return clamp_fix(acc);
  endfunction

  function automatic fix_t acc_add(input fix_t a, input fix_t b);
    logic signed [63:0] t;
    t = a;
    t += b;
    return clamp_fix(t);
  endfunction

  // Apply one accepted beat to the predictor; queue the vertex it produces, if any.
  task automatic transform_vertex(input vert_req_t r);
    vert_res_t res;
    fix_t      rp;
    fix_t      rn;
    res = '0;
    case (r.cmd)
      CMD_LOAD: begin
        if (r.idx < MatDepth) mat[r.idx] = r.val;
      end
      CMD_POINT, CMD_DIR: begin
        for (int k = 0; k < 3; k++) begin
          res[k] = row_dot(k, r.px, r.py, r.pz, r.scale, r.cmd == CMD_POINT);
        end
        expected_vertices.push_back(res);
      end
      CMD_SKIN_SET, CMD_SKIN_ADD: begin
        for (int k = 0; k < 3; k++) begin
          rp = row_dot(k, r.px, r.py, r.pz, r.scale, 1'b1);
          rn = row_dot(k, r.nx, r.ny, r.nz, r.scale, 1'b0);
          if (r.cmd == CMD_SKIN_SET) begin
            pacc[k] = rp;
            nacc[k] = rn;
          end else begin
            pacc[k] = acc_add(pacc[k], rp);
            nacc[k] = acc_add(nacc[k], rn);
          end
          res[k]   = pacc[k];
          res[k+3] = nacc[k];
        end
        expected_vertices.push_back(res);
      end
      default: ;  // spare codes: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sender gaps: calm stretches with no idling, otherwise random idling.
  function automatic logic [3:0] draw_gap();
    if ((vertex_jobs.size() / 60) % 4 == 1) return 4'd0;
    return 4'($urandom_range(0, 8));
  endfunction

  // Mostly values near unity so sums stay in range; some full-range and corner values.
  function automatic fix_t rand_fix();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      case ($urandom_range(0, 5))
        0:       return FixMax;
        1:       return FixMin;
        2:       return '0;
        3:       return -32'sd1;
        4:       return FixOne;
        default: return FixNegOne;
      endcase
    end
    if (k <= 2) return fix_t'($urandom());
    return fix_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  task automatic queue_beat(input logic [2:0] c, input logic [3:0] i, input fix_t v,
                            input fix_t px, input fix_t py, input fix_t pz,
                            input fix_t nx, input fix_t ny, input fix_t nz, input fix_t s);
    vert_req_t r;
    r = '{cmd: c, idx: i, val: v, px: px, py: py, pz: pz, nx: nx, ny: ny, nz: nz,
          scale: s, gap: draw_gap()};
    vertex_jobs.push_back(r);
  endtask

  task automatic queue_rand(input logic [2:0] c, input logic [3:0] i);
    queue_beat(c, i, rand_fix(), rand_fix(), rand_fix(), rand_fix(),
               rand_fix(), rand_fix(), rand_fix(), rand_fix());
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers queued beats at the falling edge, holds until accepted.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_beat)) begin
      if (!staged && vertex_jobs.size() != 0) begin
        staged_req = vertex_jobs.pop_front();
        staged     = 1'b1;
        wait_left  = staged_req.gap;
      end
      if (staged && wait_left == 0) begin
        command       <= staged_req.cmd;
        element_index <= staged_req.idx;
        element_value <= staged_req.val;
        pos_x         <= staged_req.px;
        pos_y         <= staged_req.py;
        pos_z         <= staged_req.pz;
        nrm_x         <= staged_req.nx;
        nrm_y         <= staged_req.ny;
        nrm_z         <= staged_req.nz;
        scale_factor  <= staged_req.scale;
        in_valid      <= 1'b1;
        staged         = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (staged) wait_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output ready: random stall per result, plus one long hold-off partway in
  // so the result register fills and the block pushes back on its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beat) begin
        stall_left = ((out_beats / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
      end
      if (!hold_done && in_beats >= HoldAt) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results first, then predicts from the accepted input beat,
  // so a result leaving on the same edge is matched against older work.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vert_res_t got;
    vert_res_t want;
    if (rst_n) begin
      in_beat  <= in_valid && in_ready;
      out_beat <= out_valid && out_ready;

      if (out_valid && out_ready) begin
        got = {out_nrm_z, out_nrm_y, out_nrm_x, out_pos_z, out_pos_y, out_pos_x};
        out_beats++;
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected result beat, pos %0d %0d %0d nrm %0d %0d %0d", $time,
                   out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z);
          errors++;
        end else begin
          want = expected_vertices.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (want[f] !== got[f]) begin
              $display("%0t: %s expected %0d actual %0d", $time, lane_name[f],
                       $signed(want[f]), $signed(got[f]));
              errors++;
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        transform_vertex('{cmd: command, idx: element_index, val: element_value,
                           px: pos_x, py: pos_y, pz: pos_z,
                           nx: nrm_x, ny: nrm_y, nz: nrm_z,
                           scale: scale_factor, gap: 4'd0});
        in_beats++;
      end

      // Watchdog: any handshake counts as progress.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
        $display("affine_skinning_transform test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          counted;
    int unsigned pick;
    int unsigned adds;

    for (int i = 0; i < MatDepth; i++) mat[i] = '0;
    for (int k = 0; k < 3; k++) begin
      pacc[k] = '0;
      nacc[k] = '0;
    end

    // Directed: cleared matrix, add into cleared accumulators
    queue_beat(CMD_POINT, 4'd0, '0, FixOne, FixOne, FixOne, '0, '0, '0, FixOne);
    queue_beat(CMD_SKIN_ADD, 4'd0, '0, FixOne, FixNegOne, FixMax, FixOne, FixMin, '0,
               FixOne);
    // identity rotation, extreme translations
    queue_beat(CMD_LOAD, 4'd0,  FixOne,        '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_LOAD, 4'd5,  FixOne,        '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_LOAD, 4'd10, FixOne,        '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_LOAD, 4'd3,  FixMax,        '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_LOAD, 4'd7,  FixMin,        '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_LOAD, 4'd11, 32'sh0003_8000, '0, '0, '0, '0, '0, '0, '0);
    // out-of-range index and spare command must not touch state
    queue_beat(CMD_LOAD, IdxTop, FixMax, '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CmdSpareLast, 4'd1, FixMax, FixMax, FixMax, FixMax, FixMax, FixMax, FixMax,
               FixMax);
    // row sums saturating both ways
    queue_beat(CMD_POINT, 4'd0, '0, FixMax, FixMin, -32'sd1, '0, '0, '0, FixOne);
    queue_beat(CMD_DIR,   4'd0, '0, FixMax, FixMin, -32'sd1, FixMax, '0, '0, FixOne);
    queue_beat(CMD_POINT, 4'd0, '0, FixOne, FixNegOne, FixMax, '0, '0, '0, FixMin);
    queue_beat(CMD_DIR,   4'd0, '0, FixMax, FixMax, FixMax, '0, '0, '0, '0);
    // set then repeated adds until the accumulators saturate
    queue_beat(CMD_SKIN_SET, 4'd0, '0, 32'sh0002_0000, FixNegOne, '0, FixMax, FixMin,
               FixOne, FixOne);
    queue_beat(CMD_SKIN_ADD, 4'd0, '0, FixMax, FixMin, FixOne, FixMax, FixMin, FixOne,
               FixOne);
    queue_beat(CMD_SKIN_ADD, 4'd0, '0, FixMax, FixMin, FixOne, FixMax, FixMin, FixOne,
               FixNegOne);
    // off-diagonal extremes, product overflow inside the multiplier
    queue_beat(CMD_LOAD, 4'd1, FixMin, '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_LOAD, 4'd4, FixMax, '0, '0, '0, '0, '0, '0, '0);
    queue_beat(CMD_POINT, 4'd0, '0, FixMin, FixMax, '0, '0, '0, '0, FixMax);
    // floor rounding of tiny negative products
    queue_beat(CMD_SKIN_SET, 4'd0, '0, -32'sd1, -32'sd3, FixNegOne, -32'sd1, -32'sd1,
               -32'sd1, -32'sd1);
    queue_beat(CMD_DIR, 4'd0, '0, -32'sd1, -32'sd1, -32'sd1, '0, '0, '0, FixOne);

    // Random: a mix of loads, transforms and set/add skin runs,
    // with some ignored beats mixed in.
    counted = 0;
    while (counted < RandBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        queue_rand(3'($urandom_range(CmdSpareFirst, CmdSpareLast)), 4'($urandom()));
      end else if (pick < 8) begin
        queue_rand(CMD_LOAD, 4'($urandom_range(MatDepth, IdxTop)));
      end else if (pick < 35) begin
        queue_rand(CMD_LOAD, 4'($urandom_range(0, MatDepth - 1)));
        counted++;
      end else if (pick < 55) begin
        queue_rand(CMD_POINT, 4'($urandom()));
        counted++;
      end else if (pick < 70) begin
        queue_rand(CMD_DIR, 4'($urandom()));
        counted++;
      end else begin
        queue_rand(CMD_SKIN_SET, 4'($urandom()));
        adds = $urandom_range(0, 4);
        repeat (adds) queue_rand(CMD_SKIN_ADD, 4'($urandom()));
        counted += 1 + adds;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all beats handed over, every result collected, then a quiet tail
    while (vertex_jobs.size() != 0 || staged || in_valid) @(negedge clk);
    while (expected_vertices.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (errors == 0) begin
      $display("affine_skinning_transform test passed");
    end else begin
      $display("affine_skinning_transform test failed");
    end
    $finish;
  end

endmodule
